/* hdl/qpp_pkg.sv */
// Package for the quaternion pose propagator: operation codes, reset constants,
// control structs and the rounding and saturation helpers.
// No dependencies.
package qpp_pkg;

   localparam logic [2:0] OP_STEP      = 3'd0;
   localparam logic [2:0] OP_LOAD_POS  = 3'd1;
   localparam logic [2:0] OP_LOAD_VEL  = 3'd2;
   localparam logic [2:0] OP_LOAD_ORI  = 3'd3;
   localparam logic [2:0] OP_LOAD_BIAS = 3'd4;

   localparam logic [23:0] STEP_TIME_RESET = 24'd167772;
   localparam logic signed [31:0] QUAT_ONE = 32'sh4000_0000;
   localparam logic signed [63:0] QUAT_ONE_WIDE = 64'sh0000_0000_4000_0000;

   // Sign of each Hamilton product term; term t feeds component t[3:2] with
   // q[t[1:0]] * dq[t[3:2] ^ t[1:0]].
   localparam logic [15:0] HAM_NEG = 16'b0100_0010_1000_1110;

   typedef struct packed {
      logic signed [32:0] a;
      logic signed [32:0] b;
   } mul_req_type;

   typedef struct packed {
      logic busy;
      logic done;
   } norm_stat_type;

   // Round half away from zero of v / 2^sh.
   function automatic logic signed [65:0] round_shift(input logic signed [65:0] v,
                                                       input int unsigned sh);
      logic [65:0] m;
      logic [65:0] r;
      m = v[65] ? 66'(-v) : 66'(v);
      r = (m + (66'd1 << (sh - 1))) >> sh;
      return v[65] ? -$signed(r) : $signed(r);
   endfunction

   function automatic logic signed [31:0] sat32(input logic signed [65:0] v);
      if (v > 66'sh0_7FFF_FFFF) begin
         return 32'sh7FFF_FFFF;
      end else if (v < -66'sh0_8000_0000) begin
         return 32'sh8000_0000;
      end
      return 32'(v);
   endfunction

endpackage

/* hdl/qpp_req_if.sv */
// Request channel of the quaternion pose propagator: valid/ready and one item.
// No dependencies.
interface qpp_req_if;
   logic               valid;
   logic               ready;
   logic [2:0]         operation;
   logic signed [31:0] value_a;
   logic signed [31:0] value_b;
   logic signed [31:0] value_c;
   logic signed [31:0] value_d;

   modport source (output valid, operation, value_a, value_b, value_c, value_d,
                   input ready);
   modport sink   (input valid, operation, value_a, value_b, value_c, value_d,
                   output ready);
endinterface

/* hdl/qpp_rsp_if.sv */
// Response channel of the quaternion pose propagator: position and orientation.
// No dependencies.
interface qpp_rsp_if;
   logic               valid;
   logic               ready;
   logic signed [31:0] pos_x;
   logic signed [31:0] pos_y;
   logic signed [31:0] pos_z;
   logic signed [31:0] quat_w;
   logic signed [31:0] quat_x;
   logic signed [31:0] quat_y;
   logic signed [31:0] quat_z;

   modport source (output valid, pos_x, pos_y, pos_z, quat_w, quat_x, quat_y, quat_z,
                   input ready);
   modport sink   (input valid, pos_x, pos_y, pos_z, quat_w, quat_x, quat_y, quat_z,
                   output ready);
endinterface

/* hdl/qpp_mul.sv */
// Shared signed 33x33 multiplier with a registered product.
// Depends on qpp_pkg.
module qpp_mul (
   input  logic                 clock,
   input  qpp_pkg::mul_req_type operand,
   output logic signed [65:0]   product
);
   logic signed [65:0] product_ff;

   always_ff @(posedge clock) begin
      product_ff <= operand.a * operand.b;
   end

   assign product = product_ff;
endmodule

/* hdl/qpp_norm.sv */
// Iterative quaternion normaliser: scale by shifts, square sum on the shared
// multiplier, bit-serial square root, then one restoring divide per component.
// Depends on qpp_pkg.
module qpp_norm (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   start,
   input  logic signed [63:0]     in_vec [4],
   output logic signed [31:0]     out_vec [4],
   output qpp_pkg::norm_stat_type stat,
   output qpp_pkg::mul_req_type   mul_op,
   input  logic signed [65:0]     mul_product
);
   typedef enum logic [5:0] {
      N_IDLE  = 6'b000001,
      N_SCALE = 6'b000010,
      N_SQ    = 6'b000100,
      N_ROOT  = 6'b001000,
      N_LOAD  = 6'b010000,
      N_DIV   = 6'b100000
   } norm_state_type;

   norm_state_type     state_ff, state_in;
   logic               neg_ff [4], neg_in [4];
   logic [63:0]        mag_ff [4], mag_in [4];
   logic [63:0]        in_mag [4];
   logic [63:0]        in_or;
   logic [63:0]        orall_ff, orall_in;
   logic [4:0]         cnt_ff, cnt_in;
   logic [1:0]         idx_ff, idx_in;
   logic [63:0]        sum_ff, sum_in;
   logic [63:0]        res_ff, res_in;
   logic [63:0]        root_bit_ff, root_bit_in;
   logic [31:0]        rem_ff, rem_in;
   logic [31:0]        quo_ff, quo_in;
   logic signed [31:0] out_ff [4], out_in [4];
   logic               done_ff, done_in;
   logic [63:0]        trial;
   logic [61:0]        numer;
   logic [32:0]        trial_div;
   logic               qbit;
   logic [31:0]        quot;

   always_comb begin
      in_or = '0;
      for (int i = 0; i < 4; i++) begin
         in_mag[i] = in_vec[i][63] ? 64'(-in_vec[i]) : 64'(in_vec[i]);
         in_or     = in_or | in_mag[i];
      end
   end

   always_comb begin
      state_in    = state_ff;
      neg_in      = neg_ff;
      mag_in      = mag_ff;
      orall_in    = orall_ff;
      cnt_in      = cnt_ff;
      idx_in      = idx_ff;
      sum_in      = sum_ff;
      res_in      = res_ff;
      root_bit_in = root_bit_ff;
      rem_in      = rem_ff;
      quo_in      = quo_ff;
      out_in      = out_ff;
      done_in     = 1'b0;
      trial       = res_ff + root_bit_ff;
      numer       = 62'({mag_ff[idx_ff][30:0], 30'd0}) + 62'(res_ff[32:1]);
      trial_div   = {rem_ff, quo_ff[31]};
      qbit        = trial_div >= {1'b0, res_ff[31:0]};
      quot        = {quo_ff[30:0], qbit};
      unique case (state_ff)
         N_IDLE: begin
            if (start) begin
               for (int i = 0; i < 4; i++) begin
                  neg_in[i] = in_vec[i][63];
               end
               mag_in   = in_mag;
               orall_in = in_or;
               if (in_or == 64'd0) begin
                  // all zero: identity
                  out_in[0] = qpp_pkg::QUAT_ONE;
                  out_in[1] = '0;
                  out_in[2] = '0;
                  out_in[3] = '0;
                  done_in   = 1'b1;
               end else begin
                  state_in = N_SCALE;
               end
            end
         end
         N_SCALE: begin
            if (|orall_ff[63:31]) begin
               for (int i = 0; i < 4; i++) mag_in[i] = mag_ff[i] >> 1;
               orall_in = orall_ff >> 1;
            end else if (orall_ff[63:30] == 34'd0) begin
               for (int i = 0; i < 4; i++) mag_in[i] = mag_ff[i] << 1;
               orall_in = orall_ff << 1;
            end else begin
               state_in = N_SQ;
               cnt_in   = '0;
               sum_in   = '0;
            end
         end
         N_SQ: begin
            if (cnt_ff != 5'd0) sum_in = sum_ff + mul_product[63:0];
            cnt_in = 5'(cnt_ff + 5'd1);
            if (cnt_ff == 5'd4) begin
               state_in    = N_ROOT;
               res_in      = '0;
               root_bit_in = 64'h4000_0000_0000_0000;
            end
         end
         N_ROOT: begin
            if (sum_ff >= trial) begin
               sum_in = sum_ff - trial;
               res_in = (res_ff >> 1) + root_bit_ff;
            end else begin
               res_in = res_ff >> 1;
            end
            root_bit_in = root_bit_ff >> 2;
            if (root_bit_ff[0]) begin
               state_in = N_LOAD;
               idx_in   = '0;
            end
         end
         N_LOAD: begin
            rem_in   = {2'b00, numer[61:32]};
            quo_in   = numer[31:0];
            cnt_in   = '0;
            state_in = N_DIV;
         end
         N_DIV: begin
            rem_in = qbit ? 32'(trial_div - {1'b0, res_ff[31:0]}) : trial_div[31:0];
            quo_in = quot;
            cnt_in = 5'(cnt_ff + 5'd1);
            if (cnt_ff == 5'd31) begin
               if (quot > 32'h4000_0000) quot = 32'h4000_0000;
               out_in[idx_ff] = neg_ff[idx_ff] ? -$signed(quot) : $signed(quot);
               if (idx_ff == 2'd3) begin
                  done_in  = 1'b1;
                  state_in = N_IDLE;
               end else begin
                  idx_in   = 2'(idx_ff + 2'd1);
                  state_in = N_LOAD;
               end
            end
         end
         default: state_in = N_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= N_IDLE;
         done_ff  <= 1'b0;
      end else begin
         state_ff <= state_in;
         done_ff  <= done_in;
      end
      neg_ff      <= neg_in;
      mag_ff      <= mag_in;
      orall_ff    <= orall_in;
      cnt_ff      <= cnt_in;
      idx_ff      <= idx_in;
      sum_ff      <= sum_in;
      res_ff      <= res_in;
      root_bit_ff <= root_bit_in;
      rem_ff      <= rem_in;
      quo_ff      <= quo_in;
      out_ff      <= out_in;
   end

   assign mul_op.a  = {2'b00, mag_ff[cnt_ff[1:0]][30:0]};
   assign mul_op.b  = {2'b00, mag_ff[cnt_ff[1:0]][30:0]};
   assign stat.busy = state_ff != N_IDLE;
   assign stat.done = done_ff;
   assign out_vec   = out_ff;
endmodule

/* hdl/quaternion_pose_propagator.sv */
// Channel  | Dir | Handshake     | Payload
// req      | in  | valid / ready | operation, value_a .. value_d
// rsp      | out | valid / ready | pos_x .. pos_z, quat_w .. quat_z
// csr      | in  | write enable  | step_time (24 bit)
//
// Top level of the quaternion pose propagator; depends on qpp_pkg, qpp_req_if,
// qpp_rsp_if, qpp_mul and qpp_norm.
//
// A load runs one normalisation of the stored orientation between transfer
// and the next ready; a step runs four normalisations and the sequencer's
// position, increment and Hamilton phases. A normalisation takes longer for
// each scaling shift, and an all-zero quaternion skips the rest of it. The
// duration is set by the normaliser's bit-serial square root and its four
// restoring divides.
// Reset: synchronous; restores zero pose, identity orientation and default dt.
// Stalls: req is taken only while idle; a finished result waits in the output
// register and the next item is accepted meanwhile.
module quaternion_pose_propagator (
   input  logic        clock,
   input  logic        reset,
   qpp_req_if.sink     req,
   qpp_rsp_if.source   rsp,
   input  logic        csr_write_enable,
   input  logic [23:0] csr_write_data
);
   typedef enum logic [8:0] {
      S_IDLE     = 9'b000000001,
      S_NORM_Q   = 9'b000000010,
      S_POS      = 9'b000000100,
      S_RATE     = 9'b000001000,
      S_NORM_D   = 9'b000010000,
      S_HAM      = 9'b000100000,
      S_NORM_P   = 9'b001000000,
      S_NORM_OUT = 9'b010000000,
      S_OUT      = 9'b100000000
   } seq_state_type;

   seq_state_type      state_ff, state_in;
   logic [23:0]        step_time_ff;
   logic signed [31:0] pos_ff [3], pos_in [3];
   logic signed [31:0] vel_ff [3], vel_in [3];
   logic signed [31:0] bias_ff [3], bias_in [3];
   logic signed [31:0] ori_ff [4], ori_in [4];
   logic signed [31:0] val_ff [3], val_in [3];
   logic signed [31:0] q_ff [4], q_in [4];
   logic signed [31:0] dq_ff [4], dq_in [4];
   logic signed [63:0] d_ff [4], d_in [4];
   logic signed [63:0] p_ff [4], p_in [4];
   logic [4:0]         k_ff, k_in;
   logic               norm_go_ff, norm_go_in;
   logic               rsp_valid_ff, rsp_valid_in;
   logic signed [31:0] rsp_pos_ff [3], rsp_pos_in [3];
   logic signed [31:0] rsp_quat_ff [4], rsp_quat_in [4];

   logic [1:0]             pidx, cidx;
   logic [3:0]             tp, tc;
   logic signed [65:0]     mul_product;
   logic signed [65:0]     pos_sum;
   logic signed [63:0]     norm_in [4];
   logic signed [31:0]     norm_out [4];
   qpp_pkg::norm_stat_type norm_stat;
   qpp_pkg::mul_req_type   norm_mul, seq_mul, mul_sel;
   logic                   norm_active;

   qpp_mul u_mul (
      .clock   (clock),
      .operand (mul_sel),
      .product (mul_product)
   );

   qpp_norm u_norm (
      .clock       (clock),
      .reset       (reset),
      .start       (norm_go_ff),
      .in_vec      (norm_in),
      .out_vec     (norm_out),
      .stat        (norm_stat),
      .mul_op      (norm_mul),
      .mul_product (mul_product)
   );

   // present index runs one ahead of the consumed product
   assign pidx = (k_ff[1:0] == 2'd3) ? 2'd0 : k_ff[1:0];
   assign cidx = 2'(k_ff - 5'd1);
   assign tp   = k_ff[3:0];
   assign tc   = 4'(k_ff - 5'd1);

   assign norm_active = (state_ff == S_NORM_Q) || (state_ff == S_NORM_D) ||
                        (state_ff == S_NORM_P) || (state_ff == S_NORM_OUT);
   assign mul_sel     = norm_active ? norm_mul : seq_mul;

   // operand feed for the sequencer's own products
   always_comb begin
      seq_mul.a = {vel_ff[pidx][31], vel_ff[pidx]};
      seq_mul.b = {9'd0, step_time_ff};
      if (state_ff == S_RATE) begin
         seq_mul.a = {val_ff[pidx][31], val_ff[pidx]} - {bias_ff[pidx][31], bias_ff[pidx]};
      end else if (state_ff == S_HAM) begin
         seq_mul.a = {q_ff[tp[1:0]][31], q_ff[tp[1:0]]};
         seq_mul.b = {dq_ff[tp[3:2] ^ tp[1:0]][31], dq_ff[tp[3:2] ^ tp[1:0]]};
      end
   end

   // normaliser source: increment, product, or stored orientation
   always_comb begin
      for (int i = 0; i < 4; i++) begin
         norm_in[i] = {{32{ori_ff[i][31]}}, ori_ff[i]};
         if (state_ff == S_NORM_D) norm_in[i] = d_ff[i];
         if (state_ff == S_NORM_P) norm_in[i] = p_ff[i];
      end
   end

   assign pos_sum = {{34{pos_ff[cidx][31]}}, pos_ff[cidx]} +
                    qpp_pkg::round_shift(mul_product, 24);

   always_comb begin
      state_in     = state_ff;
      pos_in       = pos_ff;
      vel_in       = vel_ff;
      bias_in      = bias_ff;
      ori_in       = ori_ff;
      val_in       = val_ff;
      q_in         = q_ff;
      dq_in        = dq_ff;
      d_in         = d_ff;
      p_in         = p_ff;
      k_in         = k_ff;
      norm_go_in   = 1'b0;
      rsp_valid_in = rsp_valid_ff && !rsp.ready;
      rsp_pos_in   = rsp_pos_ff;
      rsp_quat_in  = rsp_quat_ff;
      unique case (state_ff)
         S_IDLE: begin
            if (req.valid) begin
               val_in[0]  = req.value_a;
               val_in[1]  = req.value_b;
               val_in[2]  = req.value_c;
               norm_go_in = 1'b1;
               state_in   = S_NORM_OUT;
               unique case (req.operation)
                  qpp_pkg::OP_STEP: state_in = S_NORM_Q;
                  qpp_pkg::OP_LOAD_POS: begin
                     pos_in[0] = req.value_a;
                     pos_in[1] = req.value_b;
                     pos_in[2] = req.value_c;
                  end
                  qpp_pkg::OP_LOAD_VEL: begin
                     vel_in[0] = req.value_a;
                     vel_in[1] = req.value_b;
                     vel_in[2] = req.value_c;
                  end
                  qpp_pkg::OP_LOAD_ORI: begin
                     ori_in[0] = req.value_d;
                     ori_in[1] = req.value_a;
                     ori_in[2] = req.value_b;
                     ori_in[3] = req.value_c;
                  end
                  qpp_pkg::OP_LOAD_BIAS: begin
                     bias_in[0] = req.value_a;
                     bias_in[1] = req.value_b;
                     bias_in[2] = req.value_c;
                  end
                  default: ; // unused codes load nothing and only return the current pose
               endcase
            end
         end
         S_NORM_Q: begin
            if (norm_stat.done) begin
               q_in     = norm_out;
               k_in     = '0;
               state_in = S_POS;
            end
         end
         S_POS: begin
            // advance position by rounded velocity * dt, saturated
            if (k_ff != 5'd0) pos_in[cidx] = qpp_pkg::sat32(pos_sum);
            k_in = 5'(k_ff + 5'd1);
            if (k_ff == 5'd3) begin
               k_in     = '0;
               state_in = S_RATE;
            end
         end
         S_RATE: begin
            // half-angle increment, rounded to Q2.30, full width
            if (k_ff != 5'd0) begin
               d_in[2'(cidx + 2'd1)] = 64'(qpp_pkg::round_shift(mul_product, 23));
            end
            d_in[0] = qpp_pkg::QUAT_ONE_WIDE;
            k_in    = 5'(k_ff + 5'd1);
            if (k_ff == 5'd3) begin
               norm_go_in = 1'b1;
               state_in   = S_NORM_D;
            end
         end
         S_NORM_D: begin
            if (norm_stat.done) begin
               dq_in = norm_out;
               for (int i = 0; i < 4; i++) p_in[i] = '0;
               k_in     = '0;
               state_in = S_HAM;
            end
         end
         S_HAM: begin
            // accumulate the sixteen Hamilton terms
            if (k_ff != 5'd0) begin
               p_in[tc[3:2]] = qpp_pkg::HAM_NEG[tc] ? p_ff[tc[3:2]] - mul_product[63:0]
                                                    : p_ff[tc[3:2]] + mul_product[63:0];
            end
            k_in = 5'(k_ff + 5'd1);
            if (k_ff == 5'd16) begin
               norm_go_in = 1'b1;
               state_in   = S_NORM_P;
            end
         end
         S_NORM_P: begin
            if (norm_stat.done) begin
               ori_in     = norm_out;
               norm_go_in = 1'b1;
               state_in   = S_NORM_OUT;
            end
         end
         S_NORM_OUT: begin
            if (norm_stat.done) begin
               q_in     = norm_out;
               state_in = S_OUT;
            end
         end
         S_OUT: begin
            // hold until the output register is free
            if (!rsp_valid_ff || rsp.ready) begin
               rsp_valid_in = 1'b1;
               rsp_pos_in   = pos_ff;
               rsp_quat_in  = q_ff;
               state_in     = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         step_time_ff <= qpp_pkg::STEP_TIME_RESET;
         norm_go_ff   <= 1'b0;
         rsp_valid_ff <= 1'b0;
         for (int i = 0; i < 3; i++) begin
            pos_ff[i]  <= '0;
            vel_ff[i]  <= '0;
            bias_ff[i] <= '0;
         end
         ori_ff[0] <= qpp_pkg::QUAT_ONE;
         ori_ff[1] <= '0;
         ori_ff[2] <= '0;
         ori_ff[3] <= '0;
      end else begin
         state_ff     <= state_in;
         norm_go_ff   <= norm_go_in;
         rsp_valid_ff <= rsp_valid_in;
         pos_ff       <= pos_in;
         vel_ff       <= vel_in;
         bias_ff      <= bias_in;
         ori_ff       <= ori_in;
         if (csr_write_enable) step_time_ff <= csr_write_data;
      end
      val_ff      <= val_in;
      q_ff        <= q_in;
      dq_ff       <= dq_in;
      d_ff        <= d_in;
      p_ff        <= p_in;
      k_ff        <= k_in;
      rsp_pos_ff  <= rsp_pos_in;
      rsp_quat_ff <= rsp_quat_in;
   end

   assign req.ready  = state_ff == S_IDLE;
   assign rsp.valid  = rsp_valid_ff;
   assign rsp.pos_x  = rsp_pos_ff[0];
   assign rsp.pos_y  = rsp_pos_ff[1];
   assign rsp.pos_z  = rsp_pos_ff[2];
   assign rsp.quat_w = rsp_quat_ff[0];
   assign rsp.quat_x = rsp_quat_ff[1];
   assign rsp.quat_y = rsp_quat_ff[2];
   assign rsp.quat_z = rsp_quat_ff[3];
endmodule

/* hdl/qpp_checker.sv */
// Port-level checks for the quaternion pose propagator, bound to the top level.
// Depends on quaternion_pose_propagator.
module qpp_checker (
   input logic               clock,
   input logic               reset,
   input logic               req_valid,
   input logic               req_ready,
   input logic               rsp_valid,
   input logic               rsp_ready,
   input logic signed [31:0] rsp_quat_w,
   input logic signed [31:0] rsp_quat_x
);
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_quat_w))
      else $error("stalled response dropped or changed");

   a_busy_after_req: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> !req_ready)
      else $error("ready straight after a request transfer");

   a_rsp_known: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> !$isunknown(rsp_quat_w) && !$isunknown(rsp_quat_x))
      else $error("response carries unknown orientation bits");

   a_quat_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_quat_w <= 32'sh4000_0000) && (rsp_quat_w >= -32'sh4000_0000) &&
                    (rsp_quat_x <= 32'sh4000_0000) && (rsp_quat_x >= -32'sh4000_0000))
      else $error("orientation component out of unit range");
endmodule

bind quaternion_pose_propagator qpp_checker u_qpp_checker (
   .clock      (clock),
   .reset      (reset),
   .req_valid  (req.valid),
   .req_ready  (req.ready),
   .rsp_valid  (rsp.valid),
   .rsp_ready  (rsp.ready),
   .rsp_quat_w (rsp.quat_w),
   .rsp_quat_x (rsp.quat_x)
);
